// ===== design/envelope_and_wave_address_step_macros.svh =====
// Assertion macros used by the checker of the envelope and wave address step.
`ifndef ENVELOPE_AND_WAVE_ADDRESS_STEP_MACROS_SVH
`define ENVELOPE_AND_WAVE_ADDRESS_STEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EWAS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EWAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ewas_pkg.sv =====
// Types, register codes and the envelope rate table of the envelope and wave address step.
package ewas_pkg;

   localparam int ENV_W   = 28;
   localparam int PHASE_W = 24;
   localparam int RATE_W  = 21;
   localparam int ADDR_W  = 19;
   localparam int VOL_W   = 14;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   typedef enum logic [2:0] {
      CSR_PHASE_INCREMENT = 3'd0,
      CSR_LOOP_LENGTH     = 3'd1,
      CSR_WAVE_HIGH       = 3'd2,
      CSR_VOLUME_OFFSET   = 3'd3,
      CSR_PITCH_HIGH      = 3'd4
   } csr_index_type;

   typedef enum logic {
      MODE_TICK    = 1'b0,
      MODE_SEGMENT = 1'b1
   } mode_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] seg_target;
      logic [7:0] seg_speed;
   } req_payload_type;

   typedef struct packed {
      logic [ENV_W-1:0]  env_level;
      logic [ADDR_W-1:0] wave_address;
      logic [VOL_W-1:0]  volume_code;
      logic              fetch_enable;
      logic              high_group;
      logic              address_group;
      logic [3:0]        interp_index;
   } rsp_payload_type;

   // Controls from the top level to the envelope unit; at most one is set per cycle.
   typedef struct packed {
      logic load;
      logic tick;
   } env_ctrl_type;

   typedef struct packed {
      logic carry_in;
      logic falling;
      logic active;
   } env_flags_type;

   // Rising half of the rate table; the falling half is the bitwise inverse.
   localparam logic [RATE_W-1:0] RATE_RISE [128] = '{
      21'h000000, 21'h000023, 21'h000026, 21'h000029,
      21'h00002d, 21'h000031, 21'h000036, 21'h00003b,
      21'h000040, 21'h000046, 21'h00004c, 21'h000052,
      21'h00005a, 21'h000062, 21'h00006c, 21'h000076,
      21'h000080, 21'h00008c, 21'h000098, 21'h0000a4,
      21'h0000b4, 21'h0000c4, 21'h0000d8, 21'h0000ec,
      21'h000104, 21'h00011c, 21'h000134, 21'h00014c,
      21'h00016c, 21'h00018c, 21'h0001b4, 21'h0001dc,
      21'h000200, 21'h000230, 21'h000260, 21'h000290,
      21'h0002d0, 21'h000310, 21'h000360, 21'h0003b0,
      21'h000400, 21'h000460, 21'h0004c0, 21'h000520,
      21'h0005a0, 21'h000620, 21'h0006c0, 21'h000760,
      21'h000800, 21'h0008c0, 21'h000980, 21'h000a40,
      21'h000b40, 21'h000c40, 21'h000d80, 21'h000ec0,
      21'h001000, 21'h001180, 21'h001300, 21'h001480,
      21'h001680, 21'h001880, 21'h001b00, 21'h001d80,
      21'h002000, 21'h002300, 21'h002600, 21'h002900,
      21'h002d00, 21'h003100, 21'h003600, 21'h003b00,
      21'h004000, 21'h004600, 21'h004c00, 21'h005200,
      21'h005a00, 21'h006200, 21'h006c00, 21'h007600,
      21'h008000, 21'h008c00, 21'h009800, 21'h00a400,
      21'h00b400, 21'h00c400, 21'h00d800, 21'h00ec00,
      21'h010000, 21'h011800, 21'h013000, 21'h014800,
      21'h016800, 21'h018800, 21'h01b000, 21'h01d800,
      21'h020000, 21'h023000, 21'h026000, 21'h029000,
      21'h02d000, 21'h031000, 21'h036000, 21'h03b000,
      21'h040000, 21'h046000, 21'h04c000, 21'h052000,
      21'h05a000, 21'h062000, 21'h06c000, 21'h076000,
      21'h080000, 21'h08c000, 21'h098000, 21'h0a4000,
      21'h0b4000, 21'h0c4000, 21'h0d8000, 21'h0ec000,
      21'h100000, 21'h118000, 21'h130000, 21'h148000,
      21'h168000, 21'h188000, 21'h1b0000, 21'h1d8000
   };

   // Rate lookup for a full speed byte. A falling zero speed gives a zero step.
   function automatic logic [RATE_W-1:0] rate_of(input logic [7:0] speed);
      logic [RATE_W-1:0] rise;
      rise = RATE_RISE[speed[6:0]];
      if (speed[7]) begin
         rate_of = (speed[6:0] == 7'd0) ? '0 : ~rise;
      end else begin
         rate_of = rise;
      end
   endfunction

endpackage

// ===== design/ewas_env.sv =====
// Envelope unit: segment load, step accumulation and end-of-segment snap.
module ewas_env
   import ewas_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  env_ctrl_type     ctrl,
   input  logic [7:0]       seg_target,
   input  logic [7:0]       seg_speed,
   output logic [ENV_W-1:0] level_cur,
   output logic [ENV_W-1:0] level_next
);

   logic [ENV_W-1:0]  level_ff, level_in;
   logic [ENV_W-1:0]  step_ff, step_in;
   logic [7:0]        target_ff, target_in;
   env_flags_type     flags_ff, flags_in;

   env_flags_type     load_flags;
   logic [ENV_W:0]    sum_main;
   logic [8:0]        sum_end;
   logic              at_end;
   logic [ENV_W-1:0]  tick_level;

   always_comb begin
      load_flags.active   = |seg_speed[6:0];
      load_flags.falling  = seg_speed[7];
      load_flags.carry_in = load_flags.active & load_flags.falling;

      // A falling step is the inverted rate sign-extended to 28 bits; the carry-in
      // completes the two's complement.
      sum_main = {1'b0, level_ff} + {1'b0, step_ff} + {{ENV_W{1'b0}}, flags_ff.carry_in};
      sum_end  = {1'b0, sum_main[ENV_W-1:ENV_W-8]} + {1'b0, ~target_ff} + 9'd1;
      at_end   = flags_ff.active
                 & ((sum_main[ENV_W] != flags_ff.falling) | (flags_ff.falling != sum_end[8]));
      tick_level = at_end ? {target_ff, {(ENV_W-8){1'b0}}} : sum_main[ENV_W-1:0];

      level_in  = level_ff;
      step_in   = step_ff;
      target_in = target_ff;
      flags_in  = flags_ff;
      if (ctrl.load) begin
         target_in = seg_target;
         step_in   = {(load_flags.carry_in ? 7'h7f : 7'h00), rate_of(seg_speed)};
         flags_in  = load_flags;
      end else if (ctrl.tick) begin
         level_in = tick_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         step_ff   <= '0;
         target_ff <= '0;
         flags_ff  <= '0;
      end else begin
         level_ff  <= level_in;
         step_ff   <= step_in;
         target_ff <= target_in;
         flags_ff  <= flags_in;
      end
   end

   assign level_cur  = level_ff;
   assign level_next = level_in;

endmodule

// ===== design/envelope_and_wave_address_step.sv =====
// Each transferred item is worked out in the cycle it arrives and its result
// sits in the output register from the next cycle on, so one item per clock is
// taken as long as results are taken; a single output register sets that figure,
// and while a result waits unread, req_ready follows rsp_ready. A segment item
// reloads the envelope target and step, a tick item advances the envelope and the
// wave phase; both give one result. Registers sit at byte addresses 0, 4, 8, 12
// and 16. The user must write them only while the block is idle; the block itself does not enforce this.
module envelope_and_wave_address_step
   import ewas_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready
);

   logic [PHASE_W-1:0] phase_increment_ff;
   logic [7:0]         loop_length_ff;
   logic [7:0]         wave_high_ff;
   logic [7:0]         volume_offset_ff;
   logic               pitch_high_ff;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   csr_index_type      csr_index;
   logic               csr_write;
   logic               req_transfer;
   env_ctrl_type       env_ctrl;
   logic [ENV_W-1:0]   env_cur, env_next;

   logic [PHASE_W-1:0] phase_sum;
   logic [8:0]         loop_sum;
   logic [ADDR_W-1:0]  address;
   logic               high_group;
   logic [8:0]         vol_sum;
   logic [VOL_W-1:0]   vol_raw;
   logic [VOL_W-1:0]   vol_code;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_increment_ff <= '0;
         loop_length_ff     <= '0;
         wave_high_ff       <= '0;
         volume_offset_ff   <= '0;
         pitch_high_ff      <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PHASE_INCREMENT: phase_increment_ff <= csr_pwdata[PHASE_W-1:0];
            CSR_LOOP_LENGTH:     loop_length_ff     <= csr_pwdata[7:0];
            CSR_WAVE_HIGH:       wave_high_ff       <= csr_pwdata[7:0];
            CSR_VOLUME_OFFSET:   volume_offset_ff   <= csr_pwdata[7:0];
            CSR_PITCH_HIGH:      pitch_high_ff      <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_PHASE_INCREMENT: csr_prdata = {{(CSR_DW-PHASE_W){1'b0}}, phase_increment_ff};
         CSR_LOOP_LENGTH:     csr_prdata = {24'd0, loop_length_ff};
         CSR_WAVE_HIGH:       csr_prdata = {24'd0, wave_high_ff};
         CSR_VOLUME_OFFSET:   csr_prdata = {24'd0, volume_offset_ff};
         CSR_PITCH_HIGH:      csr_prdata = {31'd0, pitch_high_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // The output register is free when empty or when its result leaves this cycle.
   assign req_ready    = ~rsp_valid_ff | rsp_ready;
   assign req_transfer = req_valid & req_ready;

   assign env_ctrl.load = req_transfer & (req_data.mode == MODE_SEGMENT);
   assign env_ctrl.tick = req_transfer & (req_data.mode == MODE_TICK);

   ewas_env u_env (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (env_ctrl),
      .seg_target (req_data.seg_target),
      .seg_speed  (req_data.seg_speed),
      .level_cur  (env_cur),
      .level_next (env_next)
   );

   always_comb begin
      // When the top byte reaches the loop point, the loop byte is subtracted from it.
      phase_sum = phase_increment_ff + phase_ff;
      loop_sum  = 9'd1 + {1'b0, phase_sum[PHASE_W-1:16]} + {1'b0, ~loop_length_ff};
      phase_in  = phase_ff;
      if (env_ctrl.tick) begin
         phase_in = {(loop_sum[8] ? loop_sum[7:0] : phase_sum[PHASE_W-1:16]),
                     phase_sum[15:0]};
      end

      address    = {wave_high_ff, phase_in[19:9]};
      high_group = pitch_high_ff | (|phase_in[PHASE_W-1:20]);

      // Volume is taken from the envelope as it stood before this item.
      vol_sum  = 9'd1 + {1'b0, env_cur[ENV_W-1:20]} + {1'b0, volume_offset_ff};
      vol_raw  = {(vol_sum[8] ? vol_sum[7:4] : 4'd0), vol_sum[3:0], env_cur[19:14]};
      vol_code = ~vol_raw;
      if (high_group) begin
         vol_code[13:10] = 4'hf;
      end

      rsp_data_in.env_level     = env_next;
      rsp_data_in.wave_address  = address;
      rsp_data_in.volume_code   = vol_code;
      rsp_data_in.fetch_enable  = (req_data.mode == MODE_TICK) & (|env_next)
                                  & (address[ADDR_W-1:17] == 2'd0);
      rsp_data_in.high_group    = high_group;
      rsp_data_in.address_group = (|address[16:14]) | (address[13] & (|address[12:11]));
      rsp_data_in.interp_index  = phase_in[8:5];

      rsp_valid_in = req_transfer | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/ewas_checker.sv =====
// Port-level checker of the envelope and wave address step and its bind statement.
`include "envelope_and_wave_address_step_macros.svh"

module ewas_checker
   import ewas_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   `EWAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed or dropped while stalled")
   `EWAS_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid && !rsp_ready, !req_ready, "input taken while a result waits unread")
   `EWAS_ASSERT_NEXT(a_segment_result, clock, reset, req_valid && req_ready && req_data.mode == MODE_SEGMENT, rsp_valid && !rsp_data.fetch_enable, "segment transfer without a non-fetching result")
   `EWAS_ASSERT_NEXT(a_tick_result, clock, reset, req_valid && req_ready && req_data.mode == MODE_TICK, rsp_valid && (!rsp_data.fetch_enable || rsp_data.env_level != 0), "tick transfer without a consistent result")

endmodule

bind envelope_and_wave_address_step ewas_checker u_checker (.*);

// ===== verif/tb_envelope_and_wave_address_step.sv =====
// Self-checking testbench for the envelope and wave address step of one part channel.
`timescale 1ns / 1ps

class sample_scoreboard;
   // Register copies, masked to their widths.
   logic [23:0] phase_step;
   logic [7:0]  loop_byte;
   logic [7:0]  wave_page;
   logic [7:0]  level_offset;
   logic        high_pitch;
   // Channel state.
   logic [27:0] envelope;
   logic [23:0] phase;
   logic [7:0]  target;
   logic [27:0] env_step;
   logic        env_active;
   logic        env_falling;
   logic        env_carry;
   logic [20:0] rise_rate [128];
   ewas_pkg::rsp_payload_type expected_samples [$];
   int errors;
   int checked;
   int segments;
   int ticks;
   int snaps;
   int fetches;

   function new();
      phase_step   = '0;
      loop_byte    = '0;
      wave_page    = '0;
      level_offset = '0;
      high_pitch   = 1'b0;
      envelope     = '0;
      phase        = '0;
      target       = '0;
      env_step     = '0;
      env_active   = 1'b0;
      env_falling  = 1'b0;
      env_carry    = 1'b0;
      errors       = 0;
      checked      = 0;
      segments     = 0;
      ticks        = 0;
      snaps        = 0;
      fetches      = 0;
      rise_rate = '{
         21'h000000, 21'h000023, 21'h000026, 21'h000029, 21'h00002d, 21'h000031, 21'h000036,
         21'h00003b, 21'h000040, 21'h000046, 21'h00004c, 21'h000052, 21'h00005a, 21'h000062,
         21'h00006c, 21'h000076, 21'h000080, 21'h00008c, 21'h000098, 21'h0000a4, 21'h0000b4,
         21'h0000c4, 21'h0000d8, 21'h0000ec, 21'h000104, 21'h00011c, 21'h000134, 21'h00014c,
         21'h00016c, 21'h00018c, 21'h0001b4, 21'h0001dc, 21'h000200, 21'h000230, 21'h000260,
         21'h000290, 21'h0002d0, 21'h000310, 21'h000360, 21'h0003b0, 21'h000400, 21'h000460,
         21'h0004c0, 21'h000520, 21'h0005a0, 21'h000620, 21'h0006c0, 21'h000760, 21'h000800,
         21'h0008c0, 21'h000980, 21'h000a40, 21'h000b40, 21'h000c40, 21'h000d80, 21'h000ec0,
         21'h001000, 21'h001180, 21'h001300, 21'h001480, 21'h001680, 21'h001880, 21'h001b00,
         21'h001d80, 21'h002000, 21'h002300, 21'h002600, 21'h002900, 21'h002d00, 21'h003100,
         21'h003600, 21'h003b00, 21'h004000, 21'h004600, 21'h004c00, 21'h005200, 21'h005a00,
         21'h006200, 21'h006c00, 21'h007600, 21'h008000, 21'h008c00, 21'h009800, 21'h00a400,
         21'h00b400, 21'h00c400, 21'h00d800, 21'h00ec00, 21'h010000, 21'h011800, 21'h013000,
         21'h014800, 21'h016800, 21'h018800, 21'h01b000, 21'h01d800, 21'h020000, 21'h023000,
         21'h026000, 21'h029000, 21'h02d000, 21'h031000, 21'h036000, 21'h03b000, 21'h040000,
         21'h046000, 21'h04c000, 21'h052000, 21'h05a000, 21'h062000, 21'h06c000, 21'h076000,
         21'h080000, 21'h08c000, 21'h098000, 21'h0a4000, 21'h0b4000, 21'h0c4000, 21'h0d8000,
         21'h0ec000, 21'h100000, 21'h118000, 21'h130000, 21'h148000, 21'h168000, 21'h188000,
         21'h1b0000, 21'h1d8000
      };
   endfunction

   function void flag(string msg);
      errors++;
      if (errors <= 10) begin
         $display("MISMATCH %s", msg);
      end
   endfunction

   function int pending();
      return expected_samples.size();
   endfunction

   // Updates the register copy and returns the value a read should give back.
   function logic [31:0] set_reg(ewas_pkg::csr_index_type idx, logic [31:0] value);
      case (idx)
         ewas_pkg::CSR_PHASE_INCREMENT: begin
            phase_step = value[23:0];
            return {8'd0, phase_step};
         end
         ewas_pkg::CSR_LOOP_LENGTH: begin
            loop_byte = value[7:0];
            return {24'd0, loop_byte};
         end
         ewas_pkg::CSR_WAVE_HIGH: begin
            wave_page = value[7:0];
            return {24'd0, wave_page};
         end
         ewas_pkg::CSR_VOLUME_OFFSET: begin
            level_offset = value[7:0];
            return {24'd0, level_offset};
         end
         ewas_pkg::CSR_PITCH_HIGH: begin
            high_pitch = value[0];
            return {31'd0, high_pitch};
         end
         default: return '0;
      endcase
   endfunction

   function void predict_sample(ewas_pkg::req_payload_type item);
      ewas_pkg::rsp_payload_type want;
      logic [27:0] prior;
      logic [28:0] env_sum;
      logic [8:0]  end_sum;
      logic [8:0]  wrap_sum;
      logic [8:0]  vol_sum;
      logic [23:0] advanced;
      logic [20:0] rate;
      logic [18:0] addr;
      logic [13:0] raw;
      logic        reached;
      logic        high;
      prior = envelope;
      if (item.mode == ewas_pkg::MODE_SEGMENT) begin
         segments++;
         env_active  = item.seg_speed[6:0] != 7'd0;
         env_falling = item.seg_speed[7];
         env_carry   = env_active && env_falling;
         rate = rise_rate[item.seg_speed[6:0]];
         // A falling step is the complement of the rising one; with the carry-in it subtracts.
         if (env_carry) begin
            rate = ~rate;
         end
         env_step = {env_carry ? 7'h7f : 7'h00, rate};
         target = item.seg_target;
      end else begin
         ticks++;
         env_sum = {1'b0, envelope} + {1'b0, env_step} + {28'd0, env_carry};
         end_sum = {1'b0, env_sum[27:20]} + {1'b0, ~target} + 9'd1;
         reached = env_active && ((env_sum[28] != env_falling) || (env_falling != end_sum[8]));
         if (reached) begin
            snaps++;
         end
         envelope = reached ? {target, 20'd0} : env_sum[27:0];
         advanced = phase + phase_step;
         wrap_sum = {1'b0, advanced[23:16]} + {1'b0, ~loop_byte} + 9'd1;
         phase = {wrap_sum[8] ? wrap_sum[7:0] : advanced[23:16], advanced[15:0]};
      end
      addr = {wave_page, 11'd0} | {8'd0, phase[19:9]};
      high = high_pitch || (phase[23:20] != 4'd0);
      // The volume follows the envelope as it stood before this step.
      vol_sum = 9'd1 + {1'b0, prior[27:20]} + {1'b0, level_offset};
      raw = {vol_sum[8] ? vol_sum[7:4] : 4'd0, vol_sum[3:0], prior[19:14]};
      want.env_level     = envelope;
      want.wave_address  = addr;
      want.volume_code   = ~raw;
      if (high) begin
         want.volume_code[13:10] = 4'hf;
      end
      want.fetch_enable  = (item.mode == ewas_pkg::MODE_TICK) && (envelope != 28'd0)
                           && (addr[18:17] == 2'd0);
      want.high_group    = high;
      want.address_group = (addr[16:14] != 3'd0) || (addr[13] && (addr[12:11] != 2'd0));
      want.interp_index  = phase[8:5];
      if (want.fetch_enable) begin
         fetches++;
      end
      expected_samples = {expected_samples, want};
   endfunction

   function void check_sample(ewas_pkg::rsp_payload_type got);
      ewas_pkg::rsp_payload_type want;
      if (expected_samples.size() == 0) begin
         flag($sformatf("result transfer with nothing outstanding: %h", got));
         return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (got !== want) begin
         flag($sformatf({"sample %0d: expected env=%h addr=%h vol=%h fetch=%b hg=%b ag=%b ",
                         "idx=%h, got env=%h addr=%h vol=%h fetch=%b hg=%b ag=%b idx=%h"},
                        checked, want.env_level, want.wave_address, want.volume_code,
                        want.fetch_enable, want.high_group, want.address_group,
                        want.interp_index, got.env_level, got.wave_address, got.volume_code,
                        got.fetch_enable, got.high_group, got.address_group,
                        got.interp_index));
      end
   endfunction
endclass

module tb_envelope_and_wave_address_step;
   import ewas_pkg::*;

   localparam logic [CSR_AW-1:0] UNUSED_CSR_ADDR = 5'd20;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_payload_type   req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_payload_type   rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   sample_scoreboard board;
   bit               steady = 1'b0;
   int               settings_run = 0;

   envelope_and_wave_address_step dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_envelope_and_wave_address_step: errors");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 7);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_sample(rsp_data);
      end
   end

   task automatic send_item(input req_payload_type item);
      if (!steady && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.predict_sample(item);
   endtask

   task automatic send_segment(input logic [7:0] level, input logic [7:0] speed);
      req_payload_type item;
      item.mode       = MODE_SEGMENT;
      item.seg_target = level;
      item.seg_speed  = speed;
      send_item(item);
   endtask

   task automatic send_tick();
      req_payload_type item;
      item.mode       = MODE_TICK;
      item.seg_target = 8'($urandom);
      item.seg_speed  = 8'($urandom);
      send_item(item);
   endtask

   // The sender holds off until every outstanding result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Back-to-back transfers keep psel high; the caller lowers it after the last one.
   task automatic csr_transfer(input bit write, input logic [CSR_AW-1:0] addr,
                               input logic [CSR_DW-1:0] data, output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   task automatic set_register(input csr_index_type idx, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] readback;
      logic [CSR_DW-1:0] want;
      csr_transfer(1'b1, {idx, 2'b00}, value, readback);
      want = board.set_reg(idx, value);
      csr_transfer(1'b0, {idx, 2'b00}, '0, readback);
      if (readback !== want) begin
         board.flag($sformatf("register %s read back %h, expected %h", idx.name(), readback,
                              want));
      end
   endtask

   task automatic apply_setting(input logic [CSR_DW-1:0] step, input logic [CSR_DW-1:0] loop,
                                input logic [CSR_DW-1:0] wave, input logic [CSR_DW-1:0] offset,
                                input logic [CSR_DW-1:0] pitch);
      set_register(CSR_PHASE_INCREMENT, step);
      set_register(CSR_LOOP_LENGTH, loop);
      set_register(CSR_WAVE_HIGH, wave);
      set_register(CSR_VOLUME_OFFSET, offset);
      set_register(CSR_PITCH_HIGH, pitch);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_run++;
   endtask

   // Mostly segments followed by runs of ticks, with some arbitrary items mixed in.
   task automatic run_random(input int quota);
      int              sent;
      int              span;
      logic [7:0]      level;
      logic [7:0]      speed;
      req_payload_type item;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(0, 9) < 2) begin
            item = 17'($urandom);
            send_item(item);
            sent++;
         end else begin
            case ($urandom_range(0, 4))
               0: speed = 8'($urandom_range(96, 127));
               1: speed = 8'($urandom_range(224, 255));
               2: speed = $urandom_range(0, 1) ? 8'h00 : 8'h80;
               default: speed = 8'($urandom);
            endcase
            // Targets near the present level make the end of a segment come soon.
            if ($urandom_range(0, 1)) begin
               level = board.envelope[27:20] + 8'($urandom_range(0, 16)) - 8'd8;
            end else begin
               level = 8'($urandom);
            end
            send_segment(level, speed);
            span = $urandom_range(1, 40);
            repeat (span) send_tick();
            sent += span + 1;
         end
      end
   endtask

   initial begin
      logic [CSR_DW-1:0] ignored;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset state, zero speeds both ways, fastest rise and fall to their ends,
      // slowest rise and fall.
      send_tick();
      send_segment(8'h00, 8'h00);
      send_tick();
      send_segment(8'hff, 8'h80);
      send_tick();
      send_segment(8'h08, 8'h7f);
      repeat (6) send_tick();
      send_segment(8'h00, 8'hff);
      repeat (6) send_tick();
      send_segment(8'hff, 8'h01);
      repeat (2) send_tick();
      send_segment(8'h00, 8'h81);
      repeat (2) send_tick();

      for (int p = 0; p < 6; p++) begin
         drain();
         case (p)
            0: begin
               // A write to an unmapped address must leave every register alone.
               csr_transfer(1'b1, UNUSED_CSR_ADDR, '1, ignored);
               apply_setting('1, '1, '1, '1, '1);
            end
            1: apply_setting(32'h0000_0123, '0, '0, '0, '0);
            default: apply_setting($urandom >> $urandom_range(0, 16), $urandom,
                                   (p < 4) ? $urandom_range(0, 63) : $urandom,
                                   $urandom, $urandom);
         endcase
         steady = (p == 1);
         run_random(92);
         steady = 1'b0;
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Ran %0d segment and %0d tick transfers across %0d register settings.",
               board.segments, board.ticks, settings_run);
      $display("The envelope hit its target %0d times and %0d samples enabled a wave fetch.",
               board.snaps, board.fetches);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb_envelope_and_wave_address_step: clean");
      end else begin
         $display("tb_envelope_and_wave_address_step: errors");
      end
      $finish;
   end

endmodule
